// ===== src/tlqs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlqs_pkg
// Shared types and codes for the two-level queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlqs_pkg;

  // Default number of entries in each ring
  localparam int unsigned QueueDepthDef = 16;

  // Opcodes
  localparam logic [1:0] OpAddInt   = 2'd0;
  localparam logic [1:0] OpAddBatch = 2'd1;
  localparam logic [1:0] OpTick     = 2'd2;

  // Status codes
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StIdle = 2'd2;

  // Queue select reported with a run
  localparam logic QueueInt   = 1'b0;
  localparam logic QueueBatch = 1'b1;

  localparam int unsigned LevelW = 5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  proc_id;
    logic [15:0] burst_len;
  } tlqs_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        ran_id;
    logic              ran_queue;
    logic [15:0]       remaining_after;
    logic              finished;
    logic [LevelW-1:0] interactive_level;
    logic [LevelW-1:0] batch_level;
  } tlqs_result_t;

  // One ring entry: process id and remaining ticks
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] rem;
  } tlqs_entry_t;

  // Ring update for one cycle. push writes at the tail, upd rewrites the
  // head in place, pop retires the head. push and pop may come together.
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        upd;
    tlqs_entry_t wdata;
  } tlqs_ring_cmd_t;

endpackage

`default_nettype wire

// ===== src/tlqs_ram.sv =====
// ----------------------------------------------------------------------------
// tlqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/tlqs_ring.sv =====
// ----------------------------------------------------------------------------
// tlqs_ring
// Circular queue of process entries: head, count, RAM and head bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_ring #(
  parameter int unsigned QueueDepth = 16,
  localparam int unsigned IdxW = $clog2(QueueDepth),
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire tlqs_pkg::tlqs_ring_cmd_t cmd_i,
  output tlqs_pkg::tlqs_entry_t        head_entry_o,
  output logic      [CntW-1:0]         count_o,
  output logic      [CntW-1:0]         count_nxt_o
);

  import tlqs_pkg::*;

  localparam int unsigned EntW = $bits(tlqs_entry_t);

  logic [IdxW-1:0] head_q, head_d, head_inc, tail, waddr;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   tail_sum;
  logic            we;
  logic            byp_q;
  tlqs_entry_t     byp_data_q;
  logic [EntW-1:0] rdata;

  // Tail slot; sum stays below twice the depth
  always_comb begin
    tail_sum = (CntW+1)'(head_q) + (CntW+1)'(count_q);
    if (tail_sum >= (CntW+1)'(QueueDepth)) begin
      tail = IdxW'(tail_sum - (CntW+1)'(QueueDepth));
    end else begin
      tail = IdxW'(tail_sum);
    end
  end

  assign head_inc = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d  = cmd_i.pop ? head_inc : head_q;
    count_d = count_q;
    if (cmd_i.push && !cmd_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop && !cmd_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  assign we    = cmd_i.push | cmd_i.upd;
  assign waddr = cmd_i.upd ? head_q : tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      // same-cycle write to the slot being read: take the new data
      byp_q   <= we && (waddr == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= cmd_i.wdata;
  end

  tlqs_ram #(
    .Width (EntW),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.wdata),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign head_entry_o = byp_q ? byp_data_q : tlqs_entry_t'(rdata);
  assign count_o      = count_q;
  assign count_nxt_o  = count_d;

endmodule

`default_nettype wire

// ===== src/two_level_queue_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// two_level_queue_scheduler_unit
// Strict-priority scheduler: round-robin interactive ring over FCFS batch ring.
// ----------------------------------------------------------------------------
// Usage:
//   An item (opcode, proc_id, burst_len) is taken on a rising edge with start
//   high and busy low. busy is always low: one item per cycle, every cycle.
//   Opcodes: add to interactive ring, add to batch ring, tick. A tick runs
//   the interactive head for one tick and requeues it unless finished;
//   with that ring empty the batch head runs in place and is popped when
//   finished. An add to a full ring reports full and changes nothing.
//   The item is registered on accept and the ring heads come out of their
//   RAMs with it; the result is registered at the next edge. done_o rises
//   at the edge that registers the result and stays high for one cycle,
//   with result_o valid in that cycle only. The receiver has no stall.
//   Throughput is one item per cycle; back-to-back items on the same ring
//   see each other's updates through a head bypass in each ring.
//   Reset (rst_ni low, async) empties both rings and drops any item in
//   flight; ring RAM contents are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_queue_scheduler_unit #(
  parameter int unsigned QueueDepth = tlqs_pkg::QueueDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tlqs_pkg::tlqs_item_t item_i,
  output logic                      done_o,
  output tlqs_pkg::tlqs_result_t    result_o
);

  import tlqs_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Input register
  logic       vld_q;
  tlqs_item_t in_q;

  // Ring interfaces
  tlqs_ring_cmd_t icmd, bcmd;
  tlqs_entry_t    ihead, bhead;
  logic [CntW-1:0] icnt, icnt_nxt, bcnt, bcnt_nxt;

  // Tick datapath
  logic         run_int, run_batch;
  tlqs_entry_t  run_ent;
  logic [15:0]  rem_after;
  logic         fin;

  tlqs_result_t res_d, res_q;
  logic         done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= item_i;
  end

  // Interactive ring has priority on a tick
  assign run_int   = vld_q && (in_q.opcode == OpTick) && (icnt != '0);
  assign run_batch = vld_q && (in_q.opcode == OpTick) && (icnt == '0) && (bcnt != '0);
  assign run_ent   = run_int ? ihead : bhead;

  // Saturating decrement: a zero-length process still finishes in one tick
  assign rem_after = (run_ent.rem == '0) ? '0 : run_ent.rem - 1'b1;
  assign fin       = (rem_after == '0);

  always_comb begin
    icmd = '0;
    bcmd = '0;
    if (vld_q) begin
      case (in_q.opcode)
        OpAddInt: begin
          icmd.push  = (icnt != CntW'(QueueDepth));
          icmd.wdata = '{id: in_q.proc_id, rem: in_q.burst_len};
        end
        OpAddBatch: begin
          bcmd.push  = (bcnt != CntW'(QueueDepth));
          bcmd.wdata = '{id: in_q.proc_id, rem: in_q.burst_len};
        end
        OpTick: begin
          // round-robin: pop head, requeue at tail if unfinished
          icmd.pop   = run_int;
          icmd.push  = run_int && !fin;
          icmd.wdata = '{id: run_ent.id, rem: rem_after};
          // FCFS: rewrite head in place, pop when done
          bcmd.upd   = run_batch && !fin;
          bcmd.pop   = run_batch && fin;
          bcmd.wdata = '{id: run_ent.id, rem: rem_after};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_d                   = '0;
    res_d.status            = StOk;
    res_d.interactive_level = LevelW'(icnt_nxt);
    res_d.batch_level       = LevelW'(bcnt_nxt);
    case (in_q.opcode)
      OpAddInt: begin
        if (icnt == CntW'(QueueDepth)) begin
          res_d.status = StFull;
        end
      end
      OpAddBatch: begin
        if (bcnt == CntW'(QueueDepth)) begin
          res_d.status = StFull;
        end
      end
      OpTick: begin
        if (run_int || run_batch) begin
          res_d.ran_id          = run_ent.id;
          res_d.ran_queue       = run_int ? QueueInt : QueueBatch;
          res_d.remaining_after = rem_after;
          res_d.finished        = fin;
        end else begin
          res_d.status = StIdle;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  tlqs_ring #(
    .QueueDepth (QueueDepth)
  ) u_int_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (icmd),
    .head_entry_o (ihead),
    .count_o      (icnt),
    .count_nxt_o  (icnt_nxt)
  );

  tlqs_ring #(
    .QueueDepth (QueueDepth)
  ) u_batch_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (bcmd),
    .head_entry_o (bhead),
    .count_o      (bcnt),
    .count_nxt_o  (bcnt_nxt)
  );

endmodule

`default_nettype wire

// ===== tb/tb_two_level_queue_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_two_level_queue_scheduler_unit
// Self-checking bench for the two-level queue scheduler. Adds and ticks are
// sent in random bursts. A local scheduler copy works out the outcome of
// each item, and every done_o strobe is checked against the oldest outcome.
// ----------------------------------------------------------------------------
module tb_two_level_queue_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlqs_pkg::*;

  localparam int unsigned QDepth = QueueDepthDef;
  // Opcode 3 has no name in the package: the block treats it as a no-op
  localparam logic [1:0] OpNop = 2'd3;
  localparam int unsigned MaxPrinted = 50;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         start;
  logic         busy;
  tlqs_item_t   item_i;
  logic         done_o;
  tlqs_result_t result_o;

  two_level_queue_scheduler_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler copy: two rings of {id, remaining}, head index and fill count.
  // --------------------------------------------------------------------------
  tlqs_entry_t  int_ring   [QDepth];
  tlqs_entry_t  batch_ring [QDepth];
  int unsigned  int_head, int_count;
  int unsigned  batch_head, batch_count;

  // Outcomes of accepted items, oldest first
  tlqs_result_t sched_outcomes [$];

  int unsigned  mismatch_cnt;
  int unsigned  result_idx;
  int unsigned  burst_left;

  // Applies one item to the copy and returns the outcome it must produce.
  function automatic tlqs_result_t schedule_item(input tlqs_item_t it);
    tlqs_result_t r;
    tlqs_entry_t  e;
    r = '0;
    r.status = StOk;
    case (it.opcode)
      OpAddInt: begin
        if (int_count == QDepth) begin
          r.status = StFull;
        end else begin
          e.id  = it.proc_id;
          e.rem = it.burst_len;
          int_ring[(int_head + int_count) % QDepth] = e;
          int_count++;
        end
      end
      OpAddBatch: begin
        if (batch_count == QDepth) begin
          r.status = StFull;
        end else begin
          e.id  = it.proc_id;
          e.rem = it.burst_len;
          batch_ring[(batch_head + batch_count) % QDepth] = e;
          batch_count++;
        end
      end
      OpTick: begin
        if (int_count != 0) begin
          // round-robin: pop head, one tick, back to tail unless done
          e = int_ring[int_head];
          int_head = (int_head + 1) % QDepth;
          int_count--;
          r.ran_id          = e.id;
          r.ran_queue       = QueueInt;
          r.remaining_after = (e.rem == 16'd0) ? 16'd0 : e.rem - 16'd1;
          if (r.remaining_after != 16'd0) begin
            e.rem = r.remaining_after;
            int_ring[(int_head + int_count) % QDepth] = e;
            int_count++;
          end else begin
            r.finished = 1'b1;
          end
        end else if (batch_count != 0) begin
          // FCFS: head runs in place, leaves only when done
          e = batch_ring[batch_head];
          r.ran_id          = e.id;
          r.ran_queue       = QueueBatch;
          r.remaining_after = (e.rem == 16'd0) ? 16'd0 : e.rem - 16'd1;
          if (r.remaining_after != 16'd0) begin
            e.rem = r.remaining_after;
            batch_ring[batch_head] = e;
          end else begin
            r.finished  = 1'b1;
            batch_head  = (batch_head + 1) % QDepth;
            batch_count--;
          end
        end else begin
          r.status = StIdle;
        end
      end
      default: ;
    endcase
    r.interactive_level = LevelW'(int_count);
    r.batch_level       = LevelW'(batch_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                result_idx, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Result checker. done_o is a one-cycle strobe with no back-pressure, so
  // every strobe seen at a rising edge is one accepted result.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tlqs_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (sched_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_idx));
      end else begin
        want = sched_outcomes.pop_front();
        check_field("status", result_o.status, want.status);
        check_field("ran_id", result_o.ran_id, want.ran_id);
        check_field("ran_queue", result_o.ran_queue, want.ran_queue);
        check_field("remaining_after", result_o.remaining_after, want.remaining_after);
        check_field("finished", result_o.finished, want.finished);
        check_field("interactive_level", result_o.interactive_level,
                    want.interactive_level);
        check_field("batch_level", result_o.batch_level, want.batch_level);
      end
      result_idx++;
    end
  end

  // --------------------------------------------------------------------------
  // Sends one item. Called at a rising edge; returns at the edge that took
  // the item. Items go out in bursts with random gaps in between; a gap of
  // zero keeps start high straight into the next burst.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [7:0] id,
                           input logic [15:0] burst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start            <= 1'b1;
    item_i.opcode    <= op;
    item_i.proc_id   <= id;
    item_i.burst_len <= burst;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    // taken at this edge
    sched_outcomes.push_back(schedule_item('{opcode: op, proc_id: id, burst_len: burst}));
    burst_left--;
  endtask

  // --------------------------------------------------------------------------
  // Directed: idle tick, no-op, batch run in place, zero burst on both rings,
  // extreme ids, interactive ring filled up and an add rejected when full.
  // --------------------------------------------------------------------------
  task automatic test_directed();
    int unsigned i;
    send_item(OpTick, 8'h00, 16'h0000);       // both rings empty: idle
    send_item(OpNop, 8'hFF, 16'hFFFF);        // opcode 3 does nothing
    send_item(OpAddBatch, 8'hA5, 16'd2);
    send_item(OpTick, 8'h00, 16'h0000);       // batch runs in place
    send_item(OpTick, 8'h00, 16'h0000);       // batch head done, popped
    send_item(OpAddInt, 8'hFF, 16'd1);
    send_item(OpAddInt, 8'h00, 16'd0);        // zero burst
    send_item(OpTick, 8'h00, 16'h0000);
    send_item(OpTick, 8'h00, 16'h0000);       // decrement saturates at zero
    for (i = 0; i < QDepth; i++)
      send_item(OpAddInt, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 2)));
    send_item(OpAddInt, 8'hFF, 16'hFFFF);     // ring full: rejected
    send_item(OpAddBatch, 8'h00, 16'd0);      // zero burst on the batch side
  endtask

  // --------------------------------------------------------------------------
  // Random mix in 40-item phases: fill-heavy, drain-heavy or balanced. Adds
  // that the copy knows will be rejected carry any 16-bit burst; accepted
  // ones stay short so the rings keep turning over.
  // --------------------------------------------------------------------------
  task automatic test_random_mix();
    int unsigned n;
    int unsigned mode;
    int unsigned pick;
    int unsigned add_pct;
    logic [1:0]  op;
    logic [15:0] burst;
    mode = 0;
    for (n = 0; n < 700; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      add_pct = (mode == 0) ? 80 : (mode == 1) ? 18 : 50;
      pick = $urandom_range(0, 99);
      if (pick < 3)            op = OpNop;
      else if (pick < add_pct) op = $urandom_range(0, 1) ? OpAddInt : OpAddBatch;
      else                     op = OpTick;
      if ((op == OpAddInt && int_count < QDepth) ||
          (op == OpAddBatch && batch_count < QDepth))
        burst = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                           : 16'($urandom_range(4, 24));
      else
        burst = 16'($urandom_range(0, 65535));
      send_item(op, 8'($urandom_range(0, 255)), burst);
    end
  endtask

  // --------------------------------------------------------------------------
  // Drain both rings, then run a long burst on the interactive ring all the
  // way down while a batch process waits behind it, then go idle.
  // --------------------------------------------------------------------------
  task automatic test_long_countdown();
    while (int_count != 0 || batch_count != 0)
      send_item(OpTick, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    send_item(OpAddInt, 8'($urandom_range(0, 255)), 16'd48);
    send_item(OpAddBatch, 8'($urandom_range(0, 255)), 16'd2);
    while (int_count != 0 || batch_count != 0)
      send_item(OpTick, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    send_item(OpTick, 8'h00, 16'h0000);       // idle again
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned guard;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    mismatch_cnt = 0;
    result_idx   = 0;
    burst_left   = 0;
    int_head     = 0;
    int_count    = 0;
    batch_head   = 0;
    batch_count  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_long_countdown();

    // let the pipe empty, with plenty of margin
    start <= 1'b0;
    guard = 0;
    while (sched_outcomes.size() != 0 && guard < 100) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (sched_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sched_outcomes.size()));

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far past the slowest legal run
  initial begin
    #24_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
